[rtl/fhrs_pkg.sv]
`default_nettype none

package fhrs_pkg;

    localparam int MAX_RINGS_DEF = 64;
    localparam int HASH_W        = 32;
    localparam int IDX_W         = 6;
    localparam int RLEN_W        = 16;
    localparam int RC_W          = 7;
    localparam int DONE_LAT      = HASH_W + 1;

    localparam logic [7:0] PROTO_TCP  = 8'd6;
    localparam logic [7:0] PROTO_UDP  = 8'd17;
    localparam logic [7:0] PROTO_SCTP = 8'd132;
    localparam logic [7:0] PROTO_ESP  = 8'd50;
    localparam logic [7:0] PROTO_AH   = 8'd51;

    localparam logic REG_RING_COUNT = 1'b0;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_HEADER,
        PH_WORD,
        PH_AH,
        PH_PORTS,
        PH_ADDRS,
        PH_BAD
    } t_phase;

    typedef enum logic [1:0] {
        ST_IN,
        ST_LOAD,
        ST_DIV,
        ST_HOLD
    } t_state;

    typedef struct packed {
        logic              open;
        logic              hash_ok;
        logic [HASH_W-1:0] hash;
    } t_parse_st;

    typedef struct packed {
        logic busy;
        logic done;
    } t_mod_st;

    function automatic logic [HASH_W-1:0] fold32(input logic [HASH_W-1:0] x);
        fold32 = x ^ {8'd0, x[31:8]} ^ {16'd0, x[31:16]} ^ {24'd0, x[31:24]};
    endfunction

endpackage

`default_nettype wire

[rtl/fhrs_byte_if.sv]
`default_nettype none

interface fhrs_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] packet_byte;
    logic       first_byte;
    logic       last_byte;
    logic       chain_end;

    modport source (
        output valid, packet_byte, first_byte, last_byte, chain_end,
        input  ready
    );
    modport sink (
        input  valid, packet_byte, first_byte, last_byte, chain_end,
        output ready
    );
endinterface

`default_nettype wire

[rtl/fhrs_ring_if.sv]
`default_nettype none

interface fhrs_ring_if;
    logic        valid;
    logic        ready;
    logic [5:0]  ring_index;
    logic        new_run;
    logic [15:0] run_length;
    logic        dropped;

    modport source (
        output valid, ring_index, new_run, run_length, dropped,
        input  ready
    );
    modport sink (
        input  valid, ring_index, new_run, run_length, dropped,
        output ready
    );
endinterface

`default_nettype wire

[rtl/fhrs_parser.sv]
`default_nettype none

module fhrs_parser
    import fhrs_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_acc,
    input  wire logic [7:0] i_byte,
    input  wire logic       i_first,
    input  wire logic       i_clr,
    output t_parse_st       o_st
);

    localparam logic [15:0] POS_VER   = 16'd0;
    localparam logic [15:0] POS_PROTO = 16'd9;
    localparam logic [15:0] POS_SRC   = 16'd12;
    localparam logic [15:0] POS_DST   = 16'd16;
    localparam logic [15:0] POS_HEND  = 16'd19;
    localparam logic [15:0] POS_MAX   = 16'hFFFF;
    localparam logic [16:0] TOFF_MAX  = 17'h0FFFB;
    localparam logic [5:0]  HLEN_MIN  = 6'd20;

    t_phase      r_phase, n_phase;
    logic [15:0] r_pos, n_pos;
    logic [5:0]  r_hlen, n_hlen;
    logic [7:0]  r_proto, n_proto;
    logic [15:0] r_toff, n_toff;
    logic [31:0] r_src, n_src;
    logic [31:0] r_dst, n_dst;
    logic [31:0] r_pword, n_pword;
    logic [2:0]  r_wcnt, n_wcnt;

    function automatic t_phase f_dispatch(input logic [7:0] proto);
        t_phase ph;
        if (proto == PROTO_TCP || proto == PROTO_UDP ||
            proto == PROTO_SCTP || proto == PROTO_ESP) begin
            ph = PH_WORD;
        end else if (proto == PROTO_AH) begin
            ph = PH_AH;
        end else begin
            ph = PH_ADDRS;
        end
        return ph;
    endfunction

    always_comb begin
        t_phase      e_phase;
        logic [15:0] e_pos;
        logic [5:0]  e_hlen;
        logic [7:0]  e_proto;
        logic [15:0] e_toff;
        logic [31:0] e_src;
        logic [31:0] e_dst;
        logic [31:0] e_pword;
        logic [2:0]  e_wcnt;
        logic [11:0] w_skip;
        logic [16:0] w_next;

        e_phase = i_first ? PH_HEADER : r_phase;
        e_pos   = i_first ? 16'd0 : r_pos;
        e_hlen  = i_first ? 6'd0 : r_hlen;
        e_proto = i_first ? 8'd0 : r_proto;
        e_toff  = i_first ? 16'd0 : r_toff;
        e_src   = i_first ? 32'd0 : r_src;
        e_dst   = i_first ? 32'd0 : r_dst;
        e_pword = i_first ? 32'd0 : r_pword;
        e_wcnt  = i_first ? 3'd0 : r_wcnt;
        w_skip  = {({2'b00, i_byte} + 10'd2), 2'b00};
        w_next  = {1'b0, e_toff} + {5'd0, w_skip};

        n_phase = r_phase;
        n_pos   = r_pos;
        n_hlen  = r_hlen;
        n_proto = r_proto;
        n_toff  = r_toff;
        n_src   = r_src;
        n_dst   = r_dst;
        n_pword = r_pword;
        n_wcnt  = r_wcnt;

        if (i_acc && (i_first || r_phase != PH_IDLE)) begin
            n_phase = e_phase;
            n_hlen  = e_hlen;
            n_proto = e_proto;
            n_toff  = e_toff;
            n_src   = e_src;
            n_dst   = e_dst;
            n_pword = e_pword;
            n_wcnt  = e_wcnt;
            n_pos   = (e_pos != POS_MAX) ? e_pos + 16'd1 : e_pos;

            if (e_pos != POS_MAX) begin
                unique case (e_phase)
                    PH_HEADER: begin
                        if (e_pos == POS_VER) begin
                            n_hlen = {i_byte[3:0], 2'b00};
                        end else if (e_pos == POS_PROTO) begin
                            n_proto = i_byte;
                        end else if (e_pos >= POS_SRC && e_pos < POS_DST) begin
                            n_src = {e_src[23:0], i_byte};
                        end else if (e_pos >= POS_DST && e_pos <= POS_HEND) begin
                            n_dst = {e_dst[23:0], i_byte};
                        end
                        if (e_pos == POS_HEND) begin
                            if (e_hlen < HLEN_MIN) begin
                                n_phase = PH_BAD;
                            end else begin
                                n_toff  = {10'd0, e_hlen};
                                n_phase = f_dispatch(e_proto);
                                n_wcnt  = 3'd0;
                                n_pword = 32'd0;
                            end
                        end
                    end
                    PH_WORD: begin
                        if (e_pos == e_toff + {13'd0, e_wcnt}) begin
                            n_pword = {e_pword[23:0], i_byte};
                            n_wcnt  = e_wcnt + 3'd1;
                            if (n_wcnt >= 3'd4) begin
                                n_phase = PH_PORTS;
                            end
                        end
                    end
                    PH_AH: begin
                        if (e_pos == e_toff) begin
                            n_proto = i_byte;
                        end else if (e_pos == e_toff + 16'd1) begin
                            if (w_next > TOFF_MAX) begin
                                n_phase = PH_BAD;
                            end else begin
                                n_toff  = w_next[15:0];
                                n_phase = f_dispatch(e_proto);
                                n_wcnt  = 3'd0;
                                n_pword = 32'd0;
                            end
                        end
                    end
                    default: begin
                    end
                endcase
            end
        end

        if (i_clr) begin
            n_phase = PH_IDLE;
        end
    end

    always_comb begin
        o_st.open    = (r_phase != PH_IDLE);
        o_st.hash_ok = (r_phase == PH_PORTS) || (r_phase == PH_ADDRS);
        o_st.hash    = (r_phase == PH_PORTS) ? fold32(r_pword)
                                             : (fold32(r_src) ^ fold32(r_dst));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_pos   <= 16'd0;
            r_hlen  <= 6'd0;
            r_proto <= 8'd0;
            r_toff  <= 16'd0;
            r_wcnt  <= 3'd0;
        end else begin
            r_phase <= n_phase;
            r_pos   <= n_pos;
            r_hlen  <= n_hlen;
            r_proto <= n_proto;
            r_toff  <= n_toff;
            r_wcnt  <= n_wcnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_src   <= n_src;
        r_dst   <= n_dst;
        r_pword <= n_pword;
    end

endmodule

`default_nettype wire

[rtl/fhrs_mod_unit.sv]
`default_nettype none

module fhrs_mod_unit
    import fhrs_pkg::*;
#(
    parameter int MAX_RINGS = MAX_RINGS_DEF
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_start,
    input  wire logic [HASH_W-1:0] i_dividend,
    input  wire logic [RC_W-1:0]   i_ring_count,
    output t_mod_st                o_st,
    output logic [IDX_W-1:0]       o_index
);

    localparam int RW    = $clog2(MAX_RINGS) + 1;
    localparam int CNT_W = $clog2(HASH_W);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(HASH_W - 1);

    logic              r_busy;
    logic              r_done;
    logic [CNT_W-1:0]  r_cnt;
    logic [HASH_W-1:0] r_div;
    logic [RW-1:0]     r_rem, n_rem;
    logic [RW-1:0]     r_rc;
    logic [RW-1:0]     w_rc;
    logic [8:0]        w_rc9;
    logic [RW:0]       w_trial;
    logic [RW+IDX_W-1:0] w_ext;

    always_comb begin
        w_rc9 = {2'b00, i_ring_count};
        if (w_rc9 == 9'd0) begin
            w_rc9 = 9'd1;
        end else if (w_rc9 > 9'(MAX_RINGS)) begin
            w_rc9 = 9'(MAX_RINGS);
        end
        w_rc = w_rc9[RW-1:0];
    end

    always_comb begin
        w_trial = {r_rem, r_div[HASH_W-1]};
        if (w_trial >= {1'b0, r_rc}) begin
            n_rem = RW'(w_trial - {1'b0, r_rc});
        end else begin
            n_rem = RW'(w_trial);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_LAST) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_div <= i_dividend;
            r_rem <= '0;
            r_rc  <= w_rc;
        end else if (r_busy) begin
            r_div <= {r_div[HASH_W-2:0], 1'b0};
            r_rem <= n_rem;
        end
    end

    assign w_ext     = {{IDX_W{1'b0}}, r_rem};
    assign o_index   = w_ext[IDX_W-1:0];
    assign o_st.busy = r_busy;
    assign o_st.done = r_done;

endmodule

`default_nettype wire

[rtl/ip_flow_hash_ring_steer_unit.sv]
// A byte that does not end a packet is taken without leaving the input state.
// A last byte that yields a hashed result reaches o_ring.valid through load, the 32-step
// remainder loop of the shared mod unit, finish and write; write waits while o_ring stalls.
// A dropped packet's result skips the mod unit: load, then write.
// i_pkt.ready stays low from a result-producing last byte until the result is registered.
// Synchronous active-low reset: idle, no open run, ring_count = 1.
`default_nettype none

module ip_flow_hash_ring_steer_unit
    import fhrs_pkg::*;
#(
    parameter int MAX_RINGS = MAX_RINGS_DEF
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    fhrs_byte_if.sink   i_pkt,
    fhrs_ring_if.source o_ring,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    t_state      r_state, n_state;
    t_parse_st   pst;
    t_mod_st     mod_st;
    logic [IDX_W-1:0] mod_index;

    logic        w_acc;
    logic        w_res;
    logic        w_ready;
    logic        w_clr;
    logic        w_start;
    logic        w_load;

    logic [RC_W-1:0]   r_ring_count;
    logic              r_cend;
    logic              r_ok;
    logic              r_out_valid, n_out_valid;
    logic [IDX_W-1:0]  r_out_idx, n_out_idx;
    logic              r_out_new, n_out_new;
    logic [RLEN_W-1:0] r_out_len, n_out_len;
    logic              r_out_drop, n_out_drop;
    logic [IDX_W-1:0]  r_prev_idx, n_prev_idx;
    logic [RLEN_W-1:0] r_batch_len, n_batch_len;
    logic              r_batch_open, n_batch_open;

    assign w_acc = i_pkt.valid && w_ready;
    assign w_res = w_acc && i_pkt.last_byte && (i_pkt.first_byte || pst.open);

    fhrs_parser u_parser (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_acc   (w_acc),
        .i_byte  (i_pkt.packet_byte),
        .i_first (i_pkt.first_byte),
        .i_clr   (w_clr),
        .o_st    (pst)
    );

    fhrs_mod_unit #(
        .MAX_RINGS (MAX_RINGS)
    ) u_mod (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (w_start),
        .i_dividend   (pst.hash),
        .i_ring_count (r_ring_count),
        .o_st         (mod_st),
        .o_index      (mod_index)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IN: begin
                if (w_res) begin
                    n_state = ST_LOAD;
                end
            end
            ST_LOAD: begin
                n_state = pst.hash_ok ? ST_DIV : ST_HOLD;
            end
            ST_DIV: begin
                if (mod_st.done) begin
                    n_state = ST_HOLD;
                end
            end
            ST_HOLD: begin
                if (!r_out_valid || o_ring.ready) begin
                    n_state = ST_IN;
                end
            end
            default: n_state = ST_IN;
        endcase
    end

    always_comb begin
        w_ready = 1'b0;
        w_clr   = 1'b0;
        w_start = 1'b0;
        w_load  = 1'b0;
        unique case (r_state)
            ST_IN:   w_ready = 1'b1;
            ST_LOAD: begin
                w_clr   = 1'b1;
                w_start = pst.hash_ok;
            end
            ST_DIV:  begin
            end
            ST_HOLD: w_load = !r_out_valid || o_ring.ready;
            default: begin
            end
        endcase
    end

    always_comb begin
        n_out_valid  = r_out_valid && !o_ring.ready;
        n_out_idx    = r_out_idx;
        n_out_new    = r_out_new;
        n_out_len    = r_out_len;
        n_out_drop   = r_out_drop;
        n_prev_idx   = r_prev_idx;
        n_batch_len  = r_batch_len;
        n_batch_open = r_batch_open;
        if (w_load) begin
            n_out_valid = 1'b1;
            if (r_ok) begin
                if (r_batch_open && mod_index == r_prev_idx) begin
                    if (r_batch_len != {RLEN_W{1'b1}}) begin
                        n_batch_len = r_batch_len + 1'b1;
                    end
                    n_out_new = 1'b0;
                end else begin
                    n_prev_idx   = mod_index;
                    n_batch_len  = RLEN_W'(1);
                    n_batch_open = 1'b1;
                    n_out_new    = 1'b1;
                end
                n_out_idx  = mod_index;
                n_out_drop = 1'b0;
            end else begin
                n_out_idx  = '0;
                n_out_new  = 1'b0;
                n_out_drop = 1'b1;
            end
            n_out_len = n_batch_len;
            if (r_cend) begin
                n_batch_open = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IN;
            r_ring_count <= RC_W'(1);
            r_out_valid  <= 1'b0;
            r_prev_idx   <= '0;
            r_batch_len  <= '0;
            r_batch_open <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_out_valid  <= n_out_valid;
            r_prev_idx   <= n_prev_idx;
            r_batch_len  <= n_batch_len;
            r_batch_open <= n_batch_open;
            if (psel && penable && pwrite && pready && paddr[2] == REG_RING_COUNT) begin
                r_ring_count <= pwdata[RC_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_res) begin
            r_cend <= i_pkt.chain_end;
        end
        if (w_clr) begin
            r_ok <= pst.hash_ok;
        end
        r_out_idx  <= n_out_idx;
        r_out_new  <= n_out_new;
        r_out_len  <= n_out_len;
        r_out_drop <= n_out_drop;
    end

    assign i_pkt.ready       = w_ready;
    assign o_ring.valid      = r_out_valid;
    assign o_ring.ring_index = r_out_idx;
    assign o_ring.new_run    = r_out_new;
    assign o_ring.run_length = r_out_len;
    assign o_ring.dropped    = r_out_drop;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_RING_COUNT) ? {{(32 - RC_W){1'b0}}, r_ring_count}
                                                 : 32'd0;

`ifndef SYNTHESIS
    a_cont_run_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ring.valid && !o_ring.dropped && !o_ring.new_run |-> o_ring.run_length >= 16'd2)
        else $error("continued run with length below two");

    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ring.valid && !o_ring.dropped |->
            ({1'b0, o_ring.ring_index} < r_ring_count) || (r_ring_count == 7'd0))
        else $error("ring index not below ring count");

    a_mod_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_start |-> ##DONE_LAT mod_st.done)
        else $error("mod unit did not finish on time");

    a_drop_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ring.valid && o_ring.dropped |-> o_ring.ring_index == 6'd0 && !o_ring.new_run)
        else $error("dropped transaction carries index or new run");
`endif

endmodule

`default_nettype wire
